// ===== src/csvw_pkg.sv =====
// Shared types and constants for the CSV record field writer.
`timescale 1ns / 1ps

package csvw_pkg;

  // Command codes on the input channel
  localparam logic [2:0] OP_BEGIN  = 3'd0;
  localparam logic [2:0] OP_BYTE   = 3'd1;
  localparam logic [2:0] OP_EMPTY  = 3'd2;
  localparam logic [2:0] OP_END    = 3'd3;
  localparam logic [2:0] OP_FINISH = 3'd4;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_INVALID  = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW = 2'd2;

  // Escape modes; any other code means no escaping
  localparam logic [1:0] ESC_DOUBLE    = 2'd0;
  localparam logic [1:0] ESC_BACKSLASH = 2'd1;

  // Configuration register indexes
  localparam logic [2:0] REG_DELIMITER   = 3'd0;
  localparam logic [2:0] REG_QUOTE       = 3'd1;
  localparam logic [2:0] REG_ESCAPE      = 3'd2;
  localparam logic [2:0] REG_QUOTE_ALL   = 3'd3;
  localparam logic [2:0] REG_QUOTE_EMPTY = 3'd4;
  localparam logic [2:0] REG_QUOTE_NEED  = 3'd5;
  localparam logic [2:0] REG_NL_BYTES    = 3'd6;
  localparam logic [2:0] REG_NL_LENGTH   = 3'd7;

  // Fixed characters
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_BSL = 8'd92;

  // Record phase
  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_RECORD = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STATUS,
    ST_CLOSE,
    ST_DELIM,
    ST_OPENQ,
    ST_READ,
    ST_BYTE,
    ST_ESC2,
    ST_CLOSEQ,
    ST_NL1,
    ST_NL2
  } state_t;

  // Character class flags from the shared compare unit
  typedef struct packed {
    logic is_quote;
    logic is_delim;
    logic is_cr;
    logic is_lf;
    logic is_bsl;
  } class_t;

endpackage

// ===== src/csvw_field_buf.sv =====
// Field byte buffer: one write port, one registered read port.
`timescale 1ns / 1ps

module csvw_field_buf #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [DEPTH];

  // write side
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read side, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/csvw_char_class.sv =====
// Shared byte compare unit: classifies one byte against the special characters.
`timescale 1ns / 1ps

module csvw_char_class (
  input  logic              [7:0] byte_in,
  input  logic              [7:0] quote_mark,
  input  logic              [7:0] delimiter_char,
  output csvw_pkg::class_t        cls
);

  always_comb begin
    cls.is_quote = (byte_in == quote_mark);
    cls.is_delim = (byte_in == delimiter_char);
    cls.is_cr    = (byte_in == csvw_pkg::CH_CR);
    cls.is_lf    = (byte_in == csvw_pkg::CH_LF);
    cls.is_bsl   = (byte_in == csvw_pkg::CH_BSL);
  end

endmodule

// ===== src/csv_record_field_writer.sv =====
// Top level of the CSV record field writer: registers, sequencer and output stage.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+--------------------------------------
//   cfg      | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//   in       | in        | in_valid/in_stall   | op, data_byte, field_end
//   out      | out       | out_valid/out_stall | out_byte, byte_valid, status, last_result
//
// A field byte without field_end is only stored; a status-only command returns a status result.
// A field close emits the delimiter, quote marks or a lone status result as needed, reads
// each buffered byte from the buffer before emitting it, and puts an escape byte before each
// escaped byte.
// A record end emits its terminator bytes.
// Rate is set by the single buffer read port and the one shared compare unit.
// rst is synchronous; it clears phase, flags, counts, state, config and out_valid only.
// A stalled output holds the sequencer; one waiting result does not block intake.
`timescale 1ns / 1ps

module csv_record_field_writer #(
  parameter int FIELD_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] op,
  input  logic [7:0] data_byte,
  input  logic       field_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [1:0] status,
  output logic       last_result
);

  localparam int CNT_W = $clog2(FIELD_DEPTH + 1);
  localparam int IDX_W = (FIELD_DEPTH > 1) ? $clog2(FIELD_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIELD_DEPTH);

  // configuration registers
  logic [7:0]  delimiter_char;
  logic [7:0]  quote_mark;
  logic [1:0]  esc_sel;
  logic        quote_all;
  logic        quote_empty;
  logic        quote_special;
  logic [15:0] newline_bytes;
  logic [1:0]  newline_length;

  // writer state
  csvw_pkg::state_t state, state_next;
  csvw_pkg::phase_t phase;
  logic             field_seen;
  logic [CNT_W-1:0] fill_cnt;
  logic             special_seen;
  logic             quote_seen;
  logic             overflow_flag;

  // per-field emission state
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] idx;
  logic             quoted;
  logic             esc_on;
  logic [1:0]       status_code;

  logic             accept;
  logic             pending;
  logic             slot_free;
  csvw_pkg::state_t dec_state;
  logic [1:0]       dec_status;
  logic             quoted_now;
  logic             at_end;
  logic             need_esc;
  logic             nl_two;
  logic             wr_en;
  logic             rd_en;
  logic [7:0]       rd_data;
  logic [7:0]       cls_in;
  csvw_pkg::class_t cls;

  logic             emit;
  logic [7:0]       e_byte;
  logic             e_bv;
  logic [1:0]       e_status;
  logic             e_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != csvw_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign pending   = (fill_cnt != '0) || overflow_flag;
  assign slot_free = !out_valid || !out_stall;
  assign nl_two    = newline_length[1];
  assign at_end    = ((idx + 1'b1) == len);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_char <= 8'd44;
      quote_mark     <= 8'd34;
      esc_sel        <= csvw_pkg::ESC_DOUBLE;
      quote_all      <= 1'b0;
      quote_empty    <= 1'b0;
      quote_special  <= 1'b1;
      newline_bytes  <= 16'd10;
      newline_length <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        csvw_pkg::REG_DELIMITER:   delimiter_char <= cfg_data[7:0];
        csvw_pkg::REG_QUOTE:       quote_mark     <= cfg_data[7:0];
        csvw_pkg::REG_ESCAPE:      esc_sel        <= cfg_data[1:0];
        csvw_pkg::REG_QUOTE_ALL:   quote_all      <= cfg_data[0];
        csvw_pkg::REG_QUOTE_EMPTY: quote_empty    <= cfg_data[0];
        csvw_pkg::REG_QUOTE_NEED:  quote_special  <= cfg_data[0];
        csvw_pkg::REG_NL_BYTES:    newline_bytes  <= cfg_data;
        csvw_pkg::REG_NL_LENGTH:   newline_length <= cfg_data[1:0];
      endcase
    end
  end

  // shared compare unit: incoming byte while idle, buffered byte otherwise
  assign cls_in = (state == csvw_pkg::ST_IDLE) ? data_byte : rd_data;

  csvw_char_class u_class (
    .byte_in        (cls_in),
    .quote_mark     (quote_mark),
    .delimiter_char (delimiter_char),
    .cls            (cls)
  );

  // field buffer
  assign wr_en = accept && (dec_status == csvw_pkg::STAT_OK) &&
                 (op == csvw_pkg::OP_BYTE) && (fill_cnt < DEPTH_C);
  assign rd_en = (state == csvw_pkg::ST_READ);

  csvw_field_buf #(
    .DEPTH (FIELD_DEPTH),
    .IDX_W (IDX_W)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_cnt[IDX_W-1:0]),
    .wr_data (data_byte),
    .rd_en   (rd_en),
    .rd_addr (idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // command decode against the current phase
  always_comb begin
    dec_state  = csvw_pkg::ST_STATUS;
    dec_status = csvw_pkg::STAT_OK;
    unique case (op)
      csvw_pkg::OP_BEGIN: begin
        if (phase != csvw_pkg::PH_IDLE) dec_status = csvw_pkg::STAT_INVALID;
      end
      csvw_pkg::OP_BYTE: begin
        if (phase != csvw_pkg::PH_RECORD) dec_status = csvw_pkg::STAT_INVALID;
        else if (field_end) dec_state = csvw_pkg::ST_CLOSE;
        else dec_state = csvw_pkg::ST_IDLE;
      end
      csvw_pkg::OP_EMPTY: begin
        if (phase != csvw_pkg::PH_RECORD || pending) dec_status = csvw_pkg::STAT_INVALID;
        else dec_state = csvw_pkg::ST_CLOSE;
      end
      csvw_pkg::OP_END: begin
        if (phase != csvw_pkg::PH_RECORD || pending) dec_status = csvw_pkg::STAT_INVALID;
        else dec_state = csvw_pkg::ST_NL1;
      end
      csvw_pkg::OP_FINISH: begin
        if (phase == csvw_pkg::PH_RECORD) begin
          if (pending) dec_status = csvw_pkg::STAT_INVALID;
          else dec_state = csvw_pkg::ST_NL1;
        end
      end
      default: dec_status = csvw_pkg::STAT_INVALID;
    endcase
  end

  // quoting decision at field close
  assign quoted_now = (fill_cnt == '0) ? (quote_all || quote_empty)
                                       : (quote_all || (quote_special && special_seen));

  // escape needed for the buffered byte now on the compare unit
  assign need_esc = esc_on &&
                    (((esc_sel == csvw_pkg::ESC_DOUBLE) && cls.is_quote) ||
                     ((esc_sel == csvw_pkg::ESC_BACKSLASH) && (cls.is_quote || cls.is_bsl)));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      csvw_pkg::ST_IDLE: begin
        if (accept) state_next = dec_state;
      end
      csvw_pkg::ST_STATUS: begin
        if (slot_free) state_next = csvw_pkg::ST_IDLE;
      end
      csvw_pkg::ST_CLOSE: begin
        if (overflow_flag) state_next = csvw_pkg::ST_STATUS;
        else if (field_seen) state_next = csvw_pkg::ST_DELIM;
        else if (quoted_now) state_next = csvw_pkg::ST_OPENQ;
        else if (fill_cnt != '0) state_next = csvw_pkg::ST_READ;
        else state_next = csvw_pkg::ST_STATUS;
      end
      csvw_pkg::ST_DELIM: begin
        if (slot_free) begin
          if (quoted) state_next = csvw_pkg::ST_OPENQ;
          else if (len != '0) state_next = csvw_pkg::ST_READ;
          else state_next = csvw_pkg::ST_IDLE;
        end
      end
      csvw_pkg::ST_OPENQ: begin
        if (slot_free) begin
          state_next = (len != '0) ? csvw_pkg::ST_READ : csvw_pkg::ST_CLOSEQ;
        end
      end
      csvw_pkg::ST_READ: state_next = csvw_pkg::ST_BYTE;
      csvw_pkg::ST_BYTE: begin
        if (slot_free) begin
          if (need_esc) state_next = csvw_pkg::ST_ESC2;
          else if (!at_end) state_next = csvw_pkg::ST_READ;
          else state_next = quoted ? csvw_pkg::ST_CLOSEQ : csvw_pkg::ST_IDLE;
        end
      end
      csvw_pkg::ST_ESC2: begin
        if (slot_free) begin
          if (!at_end) state_next = csvw_pkg::ST_READ;
          else state_next = quoted ? csvw_pkg::ST_CLOSEQ : csvw_pkg::ST_IDLE;
        end
      end
      csvw_pkg::ST_CLOSEQ: begin
        if (slot_free) state_next = csvw_pkg::ST_IDLE;
      end
      csvw_pkg::ST_NL1: begin
        if (slot_free) state_next = nl_two ? csvw_pkg::ST_NL2 : csvw_pkg::ST_IDLE;
      end
      csvw_pkg::ST_NL2: begin
        if (slot_free) state_next = csvw_pkg::ST_IDLE;
      end
      default: state_next = csvw_pkg::ST_IDLE;
    endcase
  end

  // result produced in each state
  always_comb begin
    emit     = 1'b0;
    e_byte   = 8'd0;
    e_bv     = 1'b1;
    e_status = csvw_pkg::STAT_OK;
    e_last   = 1'b0;
    unique case (state)
      csvw_pkg::ST_STATUS: begin
        emit     = 1'b1;
        e_bv     = 1'b0;
        e_status = status_code;
        e_last   = 1'b1;
      end
      csvw_pkg::ST_DELIM: begin
        emit   = 1'b1;
        e_byte = delimiter_char;
        e_last = (len == '0) && !quoted;
      end
      csvw_pkg::ST_OPENQ: begin
        emit   = 1'b1;
        e_byte = quote_mark;
      end
      csvw_pkg::ST_BYTE: begin
        emit = 1'b1;
        if (need_esc) begin
          e_byte = (esc_sel == csvw_pkg::ESC_DOUBLE) ? quote_mark : csvw_pkg::CH_BSL;
        end else begin
          e_byte = rd_data;
          e_last = at_end && !quoted;
        end
      end
      csvw_pkg::ST_ESC2: begin
        emit   = 1'b1;
        e_byte = rd_data;
        e_last = at_end && !quoted;
      end
      csvw_pkg::ST_CLOSEQ: begin
        emit   = 1'b1;
        e_byte = quote_mark;
        e_last = 1'b1;
      end
      csvw_pkg::ST_NL1: begin
        emit   = 1'b1;
        e_byte = newline_bytes[7:0];
        e_last = !nl_two;
      end
      csvw_pkg::ST_NL2: begin
        emit   = 1'b1;
        e_byte = newline_bytes[15:8];
        e_last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) state <= csvw_pkg::ST_IDLE;
    else state <= state_next;
  end

  // record and field state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= csvw_pkg::PH_IDLE;
      field_seen    <= 1'b0;
      fill_cnt      <= '0;
      special_seen  <= 1'b0;
      quote_seen    <= 1'b0;
      overflow_flag <= 1'b0;
    end else if (accept && dec_status == csvw_pkg::STAT_OK) begin
      unique case (op)
        csvw_pkg::OP_BEGIN, csvw_pkg::OP_END, csvw_pkg::OP_FINISH: begin
          if (op == csvw_pkg::OP_BEGIN) phase <= csvw_pkg::PH_RECORD;
          else if (op == csvw_pkg::OP_END) phase <= csvw_pkg::PH_IDLE;
          else phase <= csvw_pkg::PH_DONE;
          field_seen    <= 1'b0;
          fill_cnt      <= '0;
          special_seen  <= 1'b0;
          quote_seen    <= 1'b0;
          overflow_flag <= 1'b0;
        end
        csvw_pkg::OP_BYTE: begin
          if (fill_cnt < DEPTH_C) fill_cnt <= fill_cnt + 1'b1;
          else overflow_flag <= 1'b1;
          if (cls.is_quote) quote_seen <= 1'b1;
          if (cls.is_quote || cls.is_delim || cls.is_cr || cls.is_lf) special_seen <= 1'b1;
        end
        default: begin
        end
      endcase
    end else if (state == csvw_pkg::ST_CLOSE) begin
      // field taken over by the emission registers
      if (!overflow_flag) field_seen <= 1'b1;
      fill_cnt      <= '0;
      special_seen  <= 1'b0;
      quote_seen    <= 1'b0;
      overflow_flag <= 1'b0;
    end
  end

  // emission registers
  always_ff @(posedge clk) begin
    if (accept) status_code <= dec_status;
    if (state == csvw_pkg::ST_CLOSE) begin
      len         <= fill_cnt;
      idx         <= '0;
      quoted      <= quoted_now;
      esc_on      <= quoted_now || (quote_seen && !esc_sel[1]);
      status_code <= overflow_flag ? csvw_pkg::STAT_OVERFLOW : csvw_pkg::STAT_OK;
    end else if (state_next == csvw_pkg::ST_READ &&
                 (state == csvw_pkg::ST_BYTE || state == csvw_pkg::ST_ESC2)) begin
      idx <= idx + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (emit && slot_free) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit && slot_free) begin
      out_byte    <= e_byte;
      byte_valid  <= e_bv;
      status      <= e_status;
      last_result <= e_last;
    end
  end

endmodule

// ===== src/csvw_checker.sv =====
// Port-level checker for the CSV record field writer, with its bind.
`timescale 1ns / 1ps

module csvw_port_props (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] op,
  input logic       field_end,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic [1:0] status,
  input logic       last_result
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(byte_valid) &&
                               $stable(status) && $stable(last_result))
    else $error("stalled result changed");

  // a result without a byte is a lone status result, zero byte
  a_status_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last_result && out_byte == 8'd0)
    else $error("status result malformed");

  // emitted bytes always carry ok status; status code in range
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_valid ? status == csvw_pkg::STAT_OK
                              : status <= csvw_pkg::STAT_OVERFLOW))
    else $error("bad status on result");

  // any command that must answer blocks intake on the next cycle
  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (op != csvw_pkg::OP_BYTE || field_end) |=> in_stall)
    else $error("intake open while command in flight");

endmodule

bind csv_record_field_writer csvw_port_props u_csvw_port_props (.*);
